FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros for the grid traversal block.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, expr)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: design/grt_pkg.sv
// ---------------------------------------------------------------------------
// grt_pkg
// Shared types and constants of the grid ray traversal block.
// ---------------------------------------------------------------------------
package grt_pkg;
  localparam int TW = 48;
  localparam logic [TW-1:0] T_SAT = {TW{1'b1}};
  localparam int RESULT_CAP = 63;

  typedef enum logic [1:0] {
    REG_CELL_WIDTH = 2'd0,
    REG_CELL_DEPTH = 2'd1,
    REG_GRID_ROWS  = 2'd2,
    REG_GRID_COLS  = 2'd3
  } reg_idx_t;

  // request to and reply from the shared divider
  typedef struct packed {
    logic        go;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

FILE: design/grt_div.sv
// ---------------------------------------------------------------------------
// grt_div
// Unsigned restoring divider, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module grt_div import grt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  `include "assert_macros.svh"

  logic [47:0] quot;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic        done;
  logic [32:0] trial;
  logic [32:0] shifted;

  // shift in next dividend bit and try a subtract
  always_comb begin
    shifted = {rem[31:0], quot[47]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && !req.go && (cnt == 6'd1);
      if (req.go) begin
        run  <= 1'b1;
        cnt  <= 6'd48;
        quot <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (run) begin
        if (!trial[32]) begin
          rem  <= trial;
          quot <= {quot[46:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[31:0];

  `ASSERT_IMPL(a_done_ends_run, clk, rst, rsp.done |-> !run)
  `ASSERT_IMPL(a_cnt_in_range, clk, rst, run |-> (cnt != 6'd0))
  `ASSERT_NEVER(a_go_while_run, clk, rst, req.go && run)
endmodule

FILE: design/grid_ray_cell_traversal.sv
// ---------------------------------------------------------------------------
// Grid ray cell traversal: 2D grid walk of one ray.
// Input: raise start while busy is low with origin, direction and a cell
// window; the item is taken at that edge. The block clamps the window, finds
// the start cell and sets up the boundary crossing distances using one
// shared divider (six divisions: start cell, step and first crossing per
// axis), then walks one cell per cycle. Each visited cell appears on
// cell_row/cell_col for one cycle with valid high; last marks the final one.
// A ray that visits nothing gives one result with empty_res high. At most
// 63 cells per ray. busy stays high until the cycle after the last result,
// so a new ray is not accepted before all results of the previous ray are
// out. The receiver cannot stall; results are strobed.
// Configuration writes (wr_en, wr_idx, wr_data) must be made while idle.
// Reset restores the register defaults and returns to idle.
// ---------------------------------------------------------------------------
module grid_ray_cell_traversal import grt_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] win_min_row,
  input  logic signed [15:0] win_max_row,
  input  logic signed [15:0] win_min_col,
  input  logic signed [15:0] win_max_col,
  input  logic               wr_en,
  input  logic [1:0]         wr_idx,
  input  logic [30:0]        wr_data,
  output logic               valid,
  output logic [4:0]         cell_row,
  output logic [4:0]         cell_col,
  output logic               empty_res,
  output logic               last
);
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_DIVXS, S_DIVXN, S_DIVZ, S_DIVZS, S_DIVZN, S_WALK, S_EMPTY
  } state_t;

  state_t state;
  logic [30:0] cell_width, cell_depth;
  logic [5:0]  grid_rows, grid_cols;
  logic signed [31:0] ox, oz;
  logic signed [15:0] dx, dz;
  logic signed [16:0] wb0, wb1, wb2, wb3;
  logic signed [16:0] cur_row, cur_col;
  logic [47:0] nx, nz, sdx, sdz;
  logic [5:0]  n;
  logic [31:0] rem_hold;
  div_req_t req;
  div_rsp_t rsp;

  grt_div u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // effective sizes and counts
  logic [30:0] cw, cd;
  logic [5:0]  rows, cols;
  assign cw   = (cell_width == '0) ? 31'd1 : cell_width;
  assign cd   = (cell_depth == '0) ? 31'd1 : cell_depth;
  assign rows = (grid_rows == '0) ? 6'd1 :
                (grid_rows > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : grid_rows;
  assign cols = (grid_cols == '0) ? 6'd1 :
                (grid_cols > 6'(MAX_COLS)) ? 6'(MAX_COLS) : grid_cols;

  // axis operands of the current setup phase
  logic        zax;
  logic signed [31:0] oa;
  logic [30:0] csa;
  logic signed [15:0] da;
  logic [15:0] ada;
  logic [31:0] mag_rem, fl_rem, bound_dist;
  logic signed [16:0] cell0;
  always_comb begin
    zax  = (state == S_DIVZ) || (state == S_DIVZS) || (state == S_DIVZN);
    oa   = zax ? oz : ox;
    csa  = zax ? cd : cw;
    da   = zax ? dz : dx;
    ada  = da[15] ? 16'(-da) : 16'(da);
    // truncated quotient, saturated to 16-bit signed
    if (rsp.quot > 48'd32767)
      cell0 = oa[31] ? -17'sd32768 : 17'sd32767;
    else
      cell0 = oa[31] ? -$signed({1'b0, rsp.quot[15:0]}) : $signed({1'b0, rsp.quot[15:0]});
    mag_rem    = rsp.rem;
    fl_rem     = (oa[31] && mag_rem != '0) ? ({1'b0, csa} - mag_rem) : mag_rem;
    bound_dist = da[15] ? rem_hold : ({1'b0, csa} - rem_hold);
  end

  // walk step decision
  logic in_window, col_step, row_step, walk_last;
  logic [48:0] nx_sum, nz_sum;
  always_comb begin
    in_window = !(cur_row < wb0 || cur_row > wb1 || cur_col < wb2 || cur_col > wb3);
    col_step  = (dx != 0) && (dz == 0 || nx < nz);
    row_step  = !col_step && (dz != 0);
    nx_sum    = {1'b0, nx} + {1'b0, sdx};
    nz_sum    = {1'b0, nz} + {1'b0, sdz};
    // last when the cap is hit, no axis steps, or next cell leaves
    walk_last = (n == 6'(RESULT_CAP - 1)) || (!col_step && !row_step) ||
                (col_step && ((dx[15] && cur_col == wb2) ||
                              (!dx[15] && cur_col == wb3))) ||
                (row_step && ((dz[15] && cur_row == wb0) ||
                              (!dz[15] && cur_row == wb1)));
  end

  // start the divider on acceptance and after each finished division but the last
  logic issue_go;
  always_comb begin
    issue_go = ((state == S_IDLE) && start && !busy) ||
               (rsp.done && ((state == S_DIVX) || (state == S_DIVXS) ||
                             (state == S_DIVXN) || (state == S_DIVZ) ||
                             (state == S_DIVZS)));
  end

  logic signed [16:0] rmax, cmax;
  assign rmax = 17'(rows) - 17'sd1;
  assign cmax = 17'(cols) - 17'sd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= 31'd655360;
      cell_depth <= 31'd655360;
      grid_rows  <= 6'd32;
      grid_cols  <= 6'd32;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_CELL_WIDTH: cell_width <= wr_data;
        REG_CELL_DEPTH: cell_depth <= wr_data;
        REG_GRID_ROWS:  grid_rows  <= wr_data[5:0];
        REG_GRID_COLS:  grid_cols  <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      req.go <= 1'b0;
      n <= '0;
    end else begin
      valid  <= ((state == S_WALK) && in_window) || (state == S_EMPTY);
      req.go <= issue_go;
      case (state)
        S_IDLE: if (start && !busy) begin
          ox <= origin_x; oz <= origin_z; dx <= dir_x; dz <= dir_z;
          wb0 <= (win_min_row < 0) ? 17'sd0 : 17'(win_min_row);
          wb1 <= (17'(win_max_row) > rmax) ? rmax : 17'(win_max_row);
          wb2 <= (win_min_col < 0) ? 17'sd0 : 17'(win_min_col);
          wb3 <= (17'(win_max_col) > cmax) ? cmax : 17'(win_max_col);
          n <= '0;
          req.dividend <= {16'd0, (origin_x[31] ? 32'(-origin_x) : 32'(origin_x))};
          req.divisor  <= {1'b0, cw};
          state <= S_DIVX;
        end
        S_DIVX, S_DIVZ: if (rsp.done) begin
          if (zax) cur_row <= cell0; else cur_col <= cell0;
          rem_hold <= fl_rem;
          req.dividend <= {3'd0, csa, 14'd0};
          req.divisor  <= {16'd0, ada};
          state <= zax ? S_DIVZS : S_DIVXS;
        end
        S_DIVXS, S_DIVZS: if (rsp.done) begin
          if (zax) sdz <= (dz == 0) ? '0 : rsp.quot;
          else     sdx <= (dx == 0) ? '0 : rsp.quot;
          req.dividend <= {2'd0, bound_dist, 14'd0};
          req.divisor  <= {16'd0, (ada == '0) ? 16'd1 : ada};
          state <= zax ? S_DIVZN : S_DIVXN;
        end
        S_DIVXN: if (rsp.done) begin
          nx <= (dx == 0) ? T_SAT : rsp.quot;
          // start cell along z
          req.dividend <= {16'd0, (oz[31] ? 32'(-oz) : 32'(oz))};
          req.divisor  <= {1'b0, cd};
          state <= S_DIVZ;
        end
        S_DIVZN: if (rsp.done) begin
          nz <= (dz == 0) ? T_SAT : rsp.quot;
          state <= S_WALK;
        end
        S_WALK: begin
          if (!in_window) begin
            if (n == '0) state <= S_EMPTY;
            else state <= S_IDLE;
          end else begin
            cell_row  <= cur_row[4:0];
            cell_col  <= cur_col[4:0];
            empty_res <= 1'b0;
            last      <= walk_last;
            n <= n + 6'd1;
            if (col_step) begin
              nx <= nx_sum[48] ? T_SAT : nx_sum[47:0];
              cur_col <= dx[15] ? cur_col - 17'sd1 : cur_col + 17'sd1;
            end else if (row_step) begin
              nz <= nz_sum[48] ? T_SAT : nz_sum[47:0];
              cur_row <= dz[15] ? cur_row - 17'sd1 : cur_row + 17'sd1;
            end
            if (walk_last) state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          cell_row <= '0; cell_col <= '0;
          empty_res <= 1'b1; last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE) || valid;

  `ASSERT_IMPL(a_start_idle, clk, rst, (start && !busy) |=> (state == S_DIVX))
  `ASSERT_IMPL(a_empty_last, clk, rst, (valid && empty_res) |-> last)
  `ASSERT_IMPL(a_cap, clk, rst, (valid && !last) |-> (n <= 6'(RESULT_CAP - 1)))
  `ASSERT_IMPL(a_last_idle, clk, rst, (valid && last) |-> (state == S_IDLE))
endmodule
